// ===== rtl/core/ffba_pkg.sv =====
// Package for the first-fit block allocator: pool geometry, field widths,
// status codes, FSM state encoding and the control/status bundles.
// No dependencies.
package ffba_pkg;

  // Pool geometry
  localparam int NUM_BLOCKS  = 64;
  localparam int BLOCK_BYTES = 256;
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);

  // Field and internal widths
  localparam int REQ_W    = 16;                         // request_bytes, block_index
  localparam int STAT_W   = 3;
  localparam int FIRST_W  = 7;
  localparam int USED_W   = 7;
  localparam int BYTES_W  = 15;
  localparam int PTR_W    = $clog2(NUM_BLOCKS);         // block address
  localparam int CNT_W    = $clog2(NUM_BLOCKS + 1);     // run length, used count
  localparam int NEED_W   = REQ_W - BLOCK_SHIFT + 1;    // blocks wanted
  localparam int IN_DW    = 2 * REQ_W;
  localparam int OUT_DW   = STAT_W + FIRST_W + USED_W + BYTES_W;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 3'd0,
    ST_NO_SPACE     = 3'd1,
    ST_ALREADY_FREE = 3'd2,
    ST_NOT_START    = 3'd3,
    ST_BAD_INDEX    = 3'd4
  } status_t;

  // Request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Controller states, one-hot
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DECODE = 8'b0000_0010,
    S_SCAN   = 8'b0000_0100,
    S_MARK   = 8'b0000_1000,
    S_FPREV  = 8'b0001_0000,
    S_FCHK   = 8'b0010_0000,
    S_FWALK  = 8'b0100_0000,
    S_RESP   = 8'b1000_0000
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic    load;        // capture the input beat
    logic    scan_init;   // pointer and run length to zero
    logic    ptr_prev;    // pointer to block_index - 1
    logic    ptr_self;    // pointer to block_index
    logic    ptr_inc;     // pointer + 1
    logic    scan_step;   // examine one block of the first-fit scan
    logic    mark_step;   // claim one block of the found run
    logic    free_step;   // release one block of the group
    logic    set_status;
    status_t status_code;
    logic    out_load;    // move the result into the output register
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_free_req;
    logic need_big;       // more blocks than the pool holds
    logic idx_bad;
    logic idx_zero;
    logic cur_free;       // free mark at the pointer
    logic cur_end;        // group-end mark at the pointer
    logic run_hit;        // this block completes a long enough run
    logic ptr_last;       // pointer at the last block
    logic mark_last;      // pointer at the end of the run being claimed
    logic out_ready;      // output register can take a result
  } dp_stat_t;

endpackage

// ===== rtl/core/first_fit_block_allocator.sv =====
// Top level of the first-fit block allocator: joins the controller FSM
// and the datapath. Depends on ffba_pkg, ffba_ctrl and ffba_dp.
//
// Channel  Direction  Beat contents (low bits first)
// in_      slave      tdata: request_bytes[15:0], block_index[31:16]; tuser: req_type
// out_     master     tdata: status[2:0], first_block[9:3], blocks_used[16:10],
//                            bytes_used[31:17]
//
// An allocate decodes, scans block by block (up to 64 blocks) and then claims
// the found run block by block; a free on a bad index answers after decode,
// otherwise it checks the predecessor (skipped for index zero) and the first
// block, then releases the group; every walk uses the single walk pointer over the block marks.
// A result waits in the output register; a new request is taken once that
// result is loaded, and a finished one holds until the register is free.
// Reset (rst_n low, synchronous) marks every block free and clears the count.
module first_fit_block_allocator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ffba_pkg::IN_DW-1:0]         in_tdata,   // request_bytes, block_index
  input  logic [0:0]                         in_tuser,   // req_type
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ffba_pkg::OUT_DW-1:0]        out_tdata   // status, first_block,
                                                          // blocks_used, bytes_used
);

  ffba_pkg::dp_cmd_t  cmd;
  ffba_pkg::dp_stat_t stat;

  ffba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ffba_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_req_type      (in_tuser[0]),
    .in_request_bytes (in_tdata[ffba_pkg::REQ_W-1:0]),
    .in_block_index   (in_tdata[ffba_pkg::IN_DW-1:ffba_pkg::REQ_W]),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata)
  );

endmodule

// ===== rtl/core/ffba_ctrl.sv =====
// Controller FSM of the first-fit block allocator: sequences the scan,
// claim and release walks one block per cycle.
// Depends on ffba_pkg.
module ffba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  ffba_pkg::dp_stat_t stat,
  output ffba_pkg::dp_cmd_t  cmd
);

  ffba_pkg::state_t state_r, state_nxt;

  assign in_tready = (state_r == ffba_pkg::S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.status_code = ffba_pkg::ST_OK;
    unique case (state_r)
      ffba_pkg::S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ffba_pkg::S_DECODE;
        end
      end
      ffba_pkg::S_DECODE: begin
        if (!stat.is_free_req) begin
          if (stat.need_big) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ffba_pkg::ST_NO_SPACE;
            state_nxt       = ffba_pkg::S_RESP;
          end else begin
            cmd.scan_init = 1'b1;
            state_nxt     = ffba_pkg::S_SCAN;
          end
        end else begin
          priority if (stat.idx_bad) begin
            cmd.set_status  = 1'b1;
            cmd.status_code = ffba_pkg::ST_BAD_INDEX;
            state_nxt       = ffba_pkg::S_RESP;
          end else if (stat.idx_zero) begin
            cmd.ptr_self = 1'b1;
            state_nxt    = ffba_pkg::S_FCHK;
          end else begin
            cmd.ptr_prev = 1'b1;
            state_nxt    = ffba_pkg::S_FPREV;
          end
        end
      end
      // first fit: one block per cycle, run length tracked in the datapath
      ffba_pkg::S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.run_hit) begin
          state_nxt = ffba_pkg::S_MARK;
        end else if (stat.ptr_last) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ffba_pkg::ST_NO_SPACE;
          state_nxt       = ffba_pkg::S_RESP;
        end
      end
      ffba_pkg::S_MARK: begin
        cmd.mark_step = 1'b1;
        if (stat.mark_last) begin
          cmd.set_status = 1'b1;
          state_nxt      = ffba_pkg::S_RESP;
        end
      end
      // predecessor must close a group
      ffba_pkg::S_FPREV: begin
        if (!stat.cur_end) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ffba_pkg::ST_NOT_START;
          state_nxt       = ffba_pkg::S_RESP;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_nxt   = ffba_pkg::S_FCHK;
        end
      end
      ffba_pkg::S_FCHK: begin
        if (stat.cur_free) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = ffba_pkg::ST_ALREADY_FREE;
          state_nxt       = ffba_pkg::S_RESP;
        end else begin
          state_nxt = ffba_pkg::S_FWALK;
        end
      end
      ffba_pkg::S_FWALK: begin
        cmd.free_step = 1'b1;
        if (stat.cur_end || stat.ptr_last) begin
          cmd.set_status = 1'b1;
          state_nxt      = ffba_pkg::S_RESP;
        end
      end
      ffba_pkg::S_RESP: begin
        if (stat.out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ffba_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = ffba_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ffba_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/ffba_dp.sv =====
// Datapath of the first-fit block allocator: block marks, walk pointer,
// run counter, used count and the output register.
// Depends on ffba_pkg.
module ffba_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  ffba_pkg::dp_cmd_t              cmd,
  output ffba_pkg::dp_stat_t             stat,
  input  logic                           in_req_type,
  input  logic [ffba_pkg::REQ_W-1:0]     in_request_bytes,
  input  logic [ffba_pkg::REQ_W-1:0]     in_block_index,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [ffba_pkg::OUT_DW-1:0]    out_tdata
);

  localparam int NB   = ffba_pkg::NUM_BLOCKS;
  localparam int PW   = ffba_pkg::PTR_W;
  localparam int CW   = ffba_pkg::CNT_W;
  localparam int NW   = ffba_pkg::NEED_W;
  localparam int RW   = ffba_pkg::REQ_W;
  localparam int BS   = ffba_pkg::BLOCK_SHIFT;

  // Block marks, one bit per block
  logic [NB-1:0] free_r, free_nxt;
  logic [NB-1:0] gend_r, gend_nxt;

  // Request and walk registers
  logic                  req_r;
  logic [NW-1:0]         need_r;
  logic [RW-1:0]         idx_r;
  logic [PW-1:0]         ptr_r, ptr_nxt;
  logic [CW-1:0]         run_r, run_nxt;
  logic [PW-1:0]         end_r, end_nxt;
  logic [CW-1:0]         used_r, used_nxt;
  ffba_pkg::status_t     status_r;
  logic [ffba_pkg::FIRST_W-1:0] first_r, first_nxt;

  // Output register
  logic                  out_valid_r;
  logic [ffba_pkg::OUT_DW-1:0] out_data_r;

  logic [NW-1:0]         need_raw;
  logic [CW-1:0]         run_inc;
  logic                  cur_free, cur_end;
  logic [PW-1:0]         run_start;

  // Round bytes up to blocks; zero bytes takes one block
  assign need_raw = NW'(in_request_bytes[RW-1:BS]) + NW'(|in_request_bytes[BS-1:0]);

  assign cur_free  = free_r[ptr_r];
  assign cur_end   = gend_r[ptr_r];
  assign run_inc   = cur_free ? (run_r + CW'(1)) : '0;
  assign run_start = ptr_r - PW'(need_r - NW'(1));

  // Status toward the controller
  always_comb begin
    stat.is_free_req = (req_r == ffba_pkg::REQ_FREE);
    stat.need_big    = (need_r > NW'(NB));
    stat.idx_bad     = (idx_r >= RW'(NB));
    stat.idx_zero    = (idx_r == '0);
    stat.cur_free    = cur_free;
    stat.cur_end     = cur_end;
    stat.run_hit     = cur_free && (NW'(run_inc) == need_r);
    stat.ptr_last    = (ptr_r == PW'(NB - 1));
    stat.mark_last   = (ptr_r == end_r);
    stat.out_ready   = !out_valid_r || out_tready;
  end

  // Pointer, run, marks and counters
  always_comb begin
    ptr_nxt   = ptr_r;
    run_nxt   = run_r;
    end_nxt   = end_r;
    first_nxt = first_r;
    used_nxt  = used_r;
    free_nxt  = free_r;
    gend_nxt  = gend_r;
    if (cmd.load) begin
      first_nxt = ffba_pkg::FIRST_W'(NB);
    end
    if (cmd.scan_init) begin
      ptr_nxt = '0;
      run_nxt = '0;
    end
    if (cmd.ptr_prev) begin
      ptr_nxt = PW'(idx_r - RW'(1));
    end
    if (cmd.ptr_self) begin
      ptr_nxt = idx_r[PW-1:0];
    end
    if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + PW'(1);
    end
    // scan: on a hit jump back to the run start for the claim walk
    if (cmd.scan_step) begin
      run_nxt = run_inc;
      if (stat.run_hit) begin
        ptr_nxt   = run_start;
        end_nxt   = ptr_r;
        first_nxt = ffba_pkg::FIRST_W'(run_start);
      end else begin
        ptr_nxt = ptr_r + PW'(1);
      end
    end
    // claim: only the last block of the group keeps its end mark
    if (cmd.mark_step) begin
      free_nxt[ptr_r] = 1'b0;
      gend_nxt[ptr_r] = (ptr_r == end_r);
      ptr_nxt         = ptr_r + PW'(1);
      if (ptr_r == end_r) begin
        used_nxt = used_r + CW'(need_r);
      end
    end
    // release: count down only blocks that were held
    if (cmd.free_step) begin
      free_nxt[ptr_r] = 1'b1;
      gend_nxt[ptr_r] = 1'b1;
      ptr_nxt         = ptr_r + PW'(1);
      if (!cur_free && (used_r != '0)) begin
        used_nxt = used_r - CW'(1);
      end
    end
  end

  // Marks and used count reset to an empty pool
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= '1;
      gend_r <= '1;
      used_r <= '0;
    end else begin
      free_r <= free_nxt;
      gend_r <= gend_nxt;
      used_r <= used_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r  <= in_req_type;
      need_r <= (need_raw == '0) ? NW'(1) : need_raw;
      idx_r  <= in_block_index;
    end
    if (cmd.set_status) begin
      status_r <= cmd.status_code;
    end
    ptr_r   <= ptr_nxt;
    run_r   <= run_nxt;
    end_r   <= end_nxt;
    first_r <= first_nxt;
  end

  // Output register: status, first_block, blocks_used, bytes_used from bit 0
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= {ffba_pkg::BYTES_W'(ffba_pkg::BYTES_W'(used_r) << BS),
                     ffba_pkg::USED_W'(used_r),
                     first_r,
                     status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
